[hdl/dmps_pkg.sv]
// Shared types, widths and codes for the diamond maximum path sum unit.
`timescale 1ns / 1ps
`default_nettype none

package dmps_pkg;

  localparam int VALUE_W = 16;
  localparam int SUM_W = 24;
  localparam int HALF_W = 8;
  localparam int ROW_W = HALF_W + 1;
  localparam int COL_W = HALF_W;
  localparam int KIND_W = 2;
  localparam int Q_DEPTH = 2;
  localparam int OUT_DEPTH = 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [KIND_W-1:0] KIND_FIRST = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WIDEN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NARROW = 2'd2;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COL_W-1:0] col;
    logic [KIND_W-1:0] kind;
    logic has_left;
    logic has_same;
    logic last;
  } cell_t;

  function automatic logic [SUM_W-1:0] max_sum(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

[hdl/dmps_front.sv]
// Front end: grid geometry, row and column tracking, and per-cell classification.
`timescale 1ns / 1ps
`default_nettype none

module dmps_front #(
  parameter int MAX_ROWS = 128
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  input  wire logic [dmps_pkg::HALF_W-1:0]  half_rows,
  input  wire logic                         push,
  input  wire logic                         q_full,
  input  wire logic [dmps_pkg::VALUE_W-1:0] cell_value,
  output logic                              q_push,
  output dmps_pkg::cell_t                   q_cell
);

  localparam int ROW_W = dmps_pkg::ROW_W;
  localparam int COL_W = dmps_pkg::COL_W;
  localparam logic [ROW_W-1:0] MAX_H = ROW_W'((MAX_ROWS > 255) ? 255 : MAX_ROWS);

  logic [ROW_W-1:0] h_eff;
  logic [ROW_W-1:0] total;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;

  logic [ROW_W-1:0] h_next;
  logic [ROW_W-1:0] width;
  logic [ROW_W-1:0] col_ext;
  logic             widen;
  logic             end_row;
  logic             last;

  always_comb begin
    if (half_rows == '0) begin
      h_next = ROW_W'(1);
    end else if ({1'b0, half_rows} > MAX_H) begin
      h_next = MAX_H;
    end else begin
      h_next = {1'b0, half_rows};
    end
  end

  assign col_ext = {1'b0, col};
  assign widen = row < h_eff;
  assign width = widen ? (row + ROW_W'(1)) : (total - row);
  assign end_row = (col_ext + ROW_W'(1)) == width;
  assign last = end_row && ((row + ROW_W'(1)) == total);

  assign q_push = push && !q_full;

  always_comb begin
    q_cell.value = cell_value;
    q_cell.col = col;
    if (row == '0) begin
      q_cell.kind = dmps_pkg::KIND_FIRST;
    end else if (widen) begin
      q_cell.kind = dmps_pkg::KIND_WIDEN;
    end else begin
      q_cell.kind = dmps_pkg::KIND_NARROW;
    end
    q_cell.has_left = col != '0;
    q_cell.has_same = col_ext < row;
    q_cell.last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_eff <= ROW_W'(1);
      total <= ROW_W'(1);
      row <= '0;
      col <= '0;
    end else if (cfg_valid) begin
      h_eff <= h_next;
      total <= (h_next << 1) - ROW_W'(1);
      row <= '0;
      col <= '0;
    end else if (q_push) begin
      if (end_row) begin
        col <= '0;
        row <= last ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  a_col_in_row: assert property (@(posedge clk) disable iff (rst) col_ext < width)
    else $error("column index beyond row width");

endmodule

`default_nettype wire

[hdl/dmps_cell_queue.sv]
// Short queue of classified cells between front and back.
`timescale 1ns / 1ps
`default_nettype none

module dmps_cell_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire dmps_pkg::cell_t wr_cell,
  output logic                 full,
  output logic                 empty,
  input  wire logic            pop,
  output dmps_pkg::cell_t      rd_cell
);

  localparam int DEPTH = dmps_pkg::Q_DEPTH;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dmps_pkg::cell_t entries [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full = count == CW'(DEPTH);
  assign empty = count == '0;
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rd_cell = entries[rp];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wp] <= wr_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  a_push_fills: assert property (@(posedge clk) disable iff (rst) do_push |=> !empty)
    else $error("cell queue empty after a transfer in");

endmodule

`default_nettype wire

[hdl/dmps_back.sv]
// Back end: row buffer, two-stage read and update with forwarding, result queue.
`timescale 1ns / 1ps
`default_nettype none

module dmps_back #(
  parameter int MAX_ROWS = 128
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       q_empty,
  input  wire dmps_pkg::cell_t            q_cell,
  output logic                            q_pop,
  output logic                            empty,
  input  wire logic                       pop,
  output logic [dmps_pkg::SUM_W-1:0]      best_sum
);

  localparam int SUM_W = dmps_pkg::SUM_W;
  localparam int AW = $clog2(MAX_ROWS);
  localparam int OD = dmps_pkg::OUT_DEPTH;
  localparam int OPW = (OD > 1) ? $clog2(OD) : 1;
  localparam int OCW = $clog2(OD + 1);

  logic [SUM_W-1:0] row_best [MAX_ROWS];

  logic             a_valid;
  dmps_pkg::cell_t  a_cell;
  logic [AW-1:0]    a_addr0;
  logic             hit0;
  logic             hit1;
  logic [SUM_W-1:0] rd0;
  logic [SUM_W-1:0] rd1;
  logic [SUM_W-1:0] last_best;
  logic [SUM_W-1:0] held_left_best;

  logic [AW-1:0]    addr0;
  logic [AW-1:0]    addr1;
  logic             pop_fire;
  logic             pend;
  logic [OCW:0]     out_need;
  logic [SUM_W-1:0] same;
  logic [SUM_W-1:0] right;
  logic [SUM_W-1:0] above;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] best;
  logic             out_push;

  logic [SUM_W-1:0] out_mem [OD];
  logic [OPW-1:0]   out_wp;
  logic [OPW-1:0]   out_rp;
  logic [OCW-1:0]   out_count;

  // Issue stage
  assign addr0 = AW'(q_cell.col);
  assign addr1 = AW'({1'b0, q_cell.col} + 9'd1);
  assign pop_fire = pop && !empty;
  assign pend = a_valid && a_cell.last;
  assign out_need = {1'b0, out_count} - (OCW + 1)'(pop_fire) + (OCW + 1)'(pend);
  assign q_pop = !q_empty && (out_need < (OCW + 1)'(OD));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      a_cell <= q_cell;
      a_addr0 <= addr0;
      hit0 <= a_valid && (a_addr0 == addr0);
      hit1 <= a_valid && (a_addr0 == addr1);
      rd0 <= row_best[addr0];
      rd1 <= row_best[addr1];
    end
    if (a_valid) begin
      row_best[a_addr0] <= best;
      last_best <= best;
    end
  end

  // Update stage
  assign same = hit0 ? last_best : rd0;
  assign right = hit1 ? last_best : rd1;

  always_comb begin
    unique case (a_cell.kind)
      dmps_pkg::KIND_FIRST: above = '0;
      dmps_pkg::KIND_WIDEN: begin
        if (a_cell.has_left && a_cell.has_same) begin
          above = dmps_pkg::max_sum(held_left_best, same);
        end else if (a_cell.has_left) begin
          above = held_left_best;
        end else begin
          above = same;
        end
      end
      dmps_pkg::KIND_NARROW: above = dmps_pkg::max_sum(same, right);
      default: above = '0;
    endcase
  end

  assign sum_wide = {1'b0, above} + (SUM_W + 1)'(a_cell.value);
  assign best = sum_wide[SUM_W] ? dmps_pkg::SUM_MAX : sum_wide[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      held_left_best <= '0;
    end else if (a_valid && (a_cell.kind == dmps_pkg::KIND_WIDEN) && a_cell.has_same) begin
      held_left_best <= same;
    end
  end

  // Result queue
  assign out_push = a_valid && a_cell.last;
  assign empty = out_count == '0;
  assign best_sum = out_mem[out_rp];

  always_ff @(posedge clk) begin
    if (out_push) begin
      out_mem[out_wp] <= best;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wp <= '0;
      out_rp <= '0;
      out_count <= '0;
    end else begin
      if (out_push) begin
        out_wp <= (out_wp == OPW'(OD - 1)) ? '0 : out_wp + OPW'(1);
      end
      if (pop_fire) begin
        out_rp <= (out_rp == OPW'(OD - 1)) ? '0 : out_rp + OPW'(1);
      end
      out_count <= out_count + OCW'(out_push) - OCW'(pop_fire);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (out_push && !pop_fire) |-> (out_count < OCW'(OD)))
    else $error("result queue overflow");

  a_first_cell: assert property (@(posedge clk) disable iff (rst)
    (a_valid && (a_cell.kind == dmps_pkg::KIND_FIRST)) |->
    ((a_cell.col == '0) && !a_cell.has_left && !a_cell.has_same))
    else $error("top cell of a grid misclassified");

endmodule

`default_nettype wire

[hdl/diamond_max_path_sum_unit.sv]
// Top level of the diamond grid maximum path sum unit.
//
// Cells of a diamond grid enter row by row, top row first, each row left to
// right: a transfer in happens when push is high and full is low. With H set
// by half_rows (0 reads as 1, values above MAX_ROWS read as MAX_ROWS) a grid
// has 2H-1 rows and H*H cells. After the final cell of a grid one best_sum is
// offered: it is valid while empty is low and is taken when pop is high.
// half_rows is written over its own channel (cfg_valid, cfg_ready always
// high), the user must write it only while the block is idle (not enforced);
// a write abandons any partial grid. Throughput: one cell per cycle while the
// result queue has room, set by the single row buffer update per cell
// (two-port read, one write, forwarding of the previous cell's sum). A result
// is offered after buffer read, then update into the result queue.
// Reset sets half_rows to 1 and clears counters and queues; the row buffer is
// not cleared, as a grid only reads entries it has written.
// While pop stays low, up to two results wait; then the back end stops, the
// two-entry cell queue fills and full rises.
`timescale 1ns / 1ps
`default_nettype none

module diamond_max_path_sum_unit #(
  parameter int MAX_ROWS = 128
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [dmps_pkg::HALF_W-1:0]  half_rows,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [dmps_pkg::VALUE_W-1:0] cell_value,
  output logic                              empty,
  input  wire logic                         pop,
  output logic [dmps_pkg::SUM_W-1:0]        best_sum
);

  logic            f_push;
  dmps_pkg::cell_t f_cell;
  logic            q_empty;
  logic            q_pop;
  dmps_pkg::cell_t q_cell;

  assign cfg_ready = 1'b1;

  dmps_front #(
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .half_rows(half_rows),
    .push(push),
    .q_full(full),
    .cell_value(cell_value),
    .q_push(f_push),
    .q_cell(f_cell)
  );

  dmps_cell_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(f_push),
    .wr_cell(f_cell),
    .full(full),
    .empty(q_empty),
    .pop(q_pop),
    .rd_cell(q_cell)
  );

  dmps_back #(
    .MAX_ROWS(MAX_ROWS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_cell(q_cell),
    .q_pop(q_pop),
    .empty(empty),
    .pop(pop),
    .best_sum(best_sum)
  );

endmodule

`default_nettype wire
